// File: src/kpce_pkg.sv
// ----------------------------------------------------------------------------
// kpce_pkg
// Shared types, constants and key mapping for the keypad change event unit.
// ----------------------------------------------------------------------------
package kpce_pkg;

  localparam int NUM_KEYS = 35;
  localparam int NUM_EV   = NUM_KEYS + 1;
  localparam int CODE_W   = 6;

  localparam logic [CODE_W-1:0] STICK_SLOT  = CODE_W'(NUM_KEYS);
  localparam logic [CODE_W-1:0] CODE_BRIGHT = CODE_W'(32);

  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_STICK = 1'b1;

  typedef logic [1:0]                level_t;
  typedef level_t [NUM_KEYS-1:0]     levels_t;
  typedef logic [NUM_EV-1:0]         pend_t;

  typedef struct packed {
    pend_t      pend;
    levels_t    levels;
    logic [7:0] x;
    logic [7:0] y;
  } change_t;

  // key levels in event order: G1..G23, M1..M3, MR, round, T1..T4,
  // brightness, click1, click2
  function automatic levels_t key_levels(input logic [7:0] g_lo,
                                         input logic [7:0] g_mid,
                                         input logic [7:0] g_hi,
                                         input logic [7:0] panel,
                                         input logic [7:0] extra);
    levels_t lv;
    for (int i = 0; i < 8; i++) begin
      lv[i]     = {1'b0, g_lo[i]};
      lv[8 + i] = {1'b0, g_mid[i]};
    end
    for (int i = 0; i < 7; i++) begin
      lv[16 + i] = {1'b0, g_hi[i]};
    end
    lv[23] = {1'b0, panel[5]};
    lv[24] = {1'b0, panel[6]};
    lv[25] = {1'b0, panel[7]};
    lv[26] = {1'b0, extra[0]};
    for (int i = 0; i < 5; i++) begin
      lv[27 + i] = {1'b0, panel[i]};
    end
    lv[32] = extra[6:5];
    lv[33] = {1'b0, extra[1]};
    lv[34] = {1'b0, extra[2]};
    return lv;
  endfunction

  // index of the lowest set bit
  function automatic logic [CODE_W-1:0] low_index(input pend_t v);
    logic [CODE_W-1:0] idx;
    idx = '0;
    for (int i = NUM_EV - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = CODE_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: src/kpce_detect.sv
// ----------------------------------------------------------------------------
// kpce_detect
// Holds the last key levels and stick position; flags what a report changes.
// ----------------------------------------------------------------------------
module kpce_detect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                stick_enable,
  input  logic [7:0]          sx,
  input  logic [7:0]          sy,
  input  logic [7:0]          g_lo,
  input  logic [7:0]          g_mid,
  input  logic [7:0]          g_hi,
  input  logic [7:0]          panel,
  input  logic [7:0]          extra,
  output kpce_pkg::change_t   chg
);

  kpce_pkg::levels_t levels_r;
  kpce_pkg::levels_t levels_new;
  logic [7:0]        sx_r;
  logic [7:0]        sy_r;
  logic              stick_ev;

  assign levels_new = kpce_pkg::key_levels(g_lo, g_mid, g_hi, panel, extra);
  assign stick_ev   = ((sx != 8'd0) || (sy != 8'd0)) && stick_enable &&
                      ((sx != sx_r) || (sy != sy_r));

  always_comb begin
    for (int i = 0; i < kpce_pkg::NUM_KEYS; i++) begin
      chg.pend[i] = (levels_new[i] != levels_r[i]);
    end
    chg.pend[kpce_pkg::NUM_KEYS] = stick_ev;
    chg.levels = levels_new;
    chg.x      = sx;
    chg.y      = sy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= '0;
      sx_r     <= 8'd0;
      sy_r     <= 8'd0;
    end else if (accept) begin
      levels_r <= levels_new;
      if (stick_ev) begin
        sx_r <= sx;
        sy_r <= sy;
      end
    end
  end

endmodule

// File: src/keypad_report_change_events_unit.sv
// ----------------------------------------------------------------------------
// keypad_report_change_events_unit
// Turns keypad reports into key change and stick move events.
// ----------------------------------------------------------------------------
// A report word is compared against the stored key levels when it is taken;
// each changed key and an optional stick move become a pending event bit.
// Events leave one per cycle unless the receiver stalls, lowest key code first
// and the stick move last, with tlast on the final event of the report. A
// report causes 0 to 36 events; the next report is taken in the cycle its
// predecessor's final event moves into the output register.
module keypad_report_change_events_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,       // stick_enable
  input  logic        in_tvalid,
  output logic        in_tready,
  // stick_x_byte[7:0], stick_y_byte[15:8], gkeys_low[23:16],
  // gkeys_mid[31:24], gkeys_high[39:32], panel_keys[47:40], extra_keys[55:48]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // key_code[5:0], key_level[7:6], stick_x[15:8], stick_y[23:16]
  output logic [23:0] out_tdata,
  output logic        out_tuser,       // event_kind
  output logic        out_tlast
);

  logic                          stick_en_r;
  kpce_pkg::change_t             chg;
  kpce_pkg::pend_t               pend_r;
  kpce_pkg::pend_t               pend_nxt;
  kpce_pkg::pend_t               low_bit;
  kpce_pkg::pend_t               pend_after;
  kpce_pkg::levels_t             levels_r;
  logic [7:0]                    x_r;
  logic [7:0]                    y_r;
  logic [kpce_pkg::CODE_W-1:0]   idx;
  logic                          emit;
  logic                          in_acc;

  logic                          out_valid_r;
  logic                          kind_r;
  logic [kpce_pkg::CODE_W-1:0]   code_r;
  logic [1:0]                    level_r;
  logic [7:0]                    ox_r;
  logic [7:0]                    oy_r;
  logic                          last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_en_r <= 1'b0;
    end else if (cfg_we) begin
      stick_en_r <= cfg_wdata;
    end
  end

  kpce_detect u_detect (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_acc),
    .stick_enable (stick_en_r),
    .sx           (in_tdata[7:0]),
    .sy           (in_tdata[15:8]),
    .g_lo         (in_tdata[23:16]),
    .g_mid        (in_tdata[31:24]),
    .g_hi         (in_tdata[39:32]),
    .panel        (in_tdata[47:40]),
    .extra        (in_tdata[55:48]),
    .chg          (chg)
  );

  assign emit       = (pend_r != '0) && (!out_valid_r || out_tready);
  assign low_bit    = pend_r & (~pend_r + kpce_pkg::pend_t'(1));
  assign pend_after = emit ? (pend_r & ~low_bit) : pend_r;
  assign idx        = kpce_pkg::low_index(pend_r);
  assign in_tready  = (pend_after == '0);
  assign in_acc     = in_tvalid && in_tready;
  assign pend_nxt   = in_acc ? chg.pend : pend_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      levels_r <= chg.levels;
      x_r      <= chg.x;
      y_r      <= chg.y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last_r <= (pend_r & ~low_bit) == '0;
      if (idx == kpce_pkg::STICK_SLOT) begin
        kind_r  <= kpce_pkg::KIND_STICK;
        code_r  <= '0;
        level_r <= 2'd0;
        ox_r    <= x_r;
        oy_r    <= y_r;
      end else begin
        kind_r  <= kpce_pkg::KIND_KEY;
        code_r  <= idx;
        level_r <= levels_r[idx];
        ox_r    <= 8'd0;
        oy_r    <= 8'd0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {oy_r, ox_r, level_r, code_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

`ifndef NO_ASSERTIONS
  // stick move is always the final event of its report
  a_stick_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == kpce_pkg::KIND_STICK) |-> last_r)
    else $error("stick event without tlast");

  // key events carry a valid key code
  a_key_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == kpce_pkg::KIND_KEY) |->
      (code_r < kpce_pkg::STICK_SLOT))
    else $error("key code out of range");

  // each emission retires exactly one pending event
  a_retire_one: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !in_acc |=> $countones(pend_r) == $countones($past(pend_r)) - 1)
    else $error("pending events not retired one at a time");

  // only brightness has a two-bit level
  a_level_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (level_r[1] == 1'b1) |->
      (kind_r == kpce_pkg::KIND_KEY) && (code_r == kpce_pkg::CODE_BRIGHT))
    else $error("wide level on a one-bit key");
`endif

endmodule

// File: sim/kpce_checker.sv
// ----------------------------------------------------------------------------
// kpce_checker
// Watches the report and event streams of the keypad change event unit. It
// keeps its own copy of the stored key bits, stick position and stick enable,
// works out the events each accepted report word must cause, and compares
// every accepted event word field by field against the oldest one due.
// ----------------------------------------------------------------------------
module kpce_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          errors,
  output int          waiting,
  output int          reports_seen,
  output int          events_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_PANEL       = 3;
  localparam int SLOT_EXTRA       = 4;
  localparam int NUM_PANEL_KEYS   = 12;
  localparam int FIRST_PANEL_CODE = 23;

  typedef struct packed {
    logic       kind;
    logic [5:0] code;
    logic [1:0] level;
    logic [7:0] sx;
    logic [7:0] sy;
    logic       last;
  } kp_event_t;

  kp_event_t  events_due [$];
  logic [7:0] held [0:4];
  logic [7:0] stored_x;
  logic [7:0] stored_y;
  logic       stick_en;

  // panel and extra keys in event order: M1, M2, M3, MR, round, T1..T4,
  // brightness, click1, click2
  task automatic panel_key(input int j, output int slot, output logic [7:0] mask,
                           output int shift);
    case (j)
      0:       begin slot = SLOT_PANEL; mask = 8'h20; shift = 5; end
      1:       begin slot = SLOT_PANEL; mask = 8'h40; shift = 6; end
      2:       begin slot = SLOT_PANEL; mask = 8'h80; shift = 7; end
      3:       begin slot = SLOT_EXTRA; mask = 8'h01; shift = 0; end
      4:       begin slot = SLOT_PANEL; mask = 8'h01; shift = 0; end
      5:       begin slot = SLOT_PANEL; mask = 8'h02; shift = 1; end
      6:       begin slot = SLOT_PANEL; mask = 8'h04; shift = 2; end
      7:       begin slot = SLOT_PANEL; mask = 8'h08; shift = 3; end
      8:       begin slot = SLOT_PANEL; mask = 8'h10; shift = 4; end
      9:       begin slot = SLOT_EXTRA; mask = 8'h60; shift = 5; end
      10:      begin slot = SLOT_EXTRA; mask = 8'h02; shift = 1; end
      default: begin slot = SLOT_EXTRA; mask = 8'h04; shift = 2; end
    endcase
  endtask

  task automatic predict_report(input logic [55:0] w);
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] m;
    logic [7:0] rb [0:4];
    kp_event_t  ev [$];
    kp_event_t  e;
    int         slot;
    int         sh;
    sx = w[7:0];
    sy = w[15:8];
    for (int k = 0; k < 5; k++) begin
      rb[k] = w[16 + 8 * k +: 8];
    end
    // G keys: bit 7 of the third byte is not a key
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 8; i++) begin
        m = 8'(1 << i);
        if (!(j == 2 && i == 7) && ((rb[j] & m) != (held[j] & m))) begin
          held[j]  = (held[j] & ~m) | (rb[j] & m);
          e        = '0;
          e.kind   = kpce_pkg::KIND_KEY;
          e.code   = 6'(j * 8 + i);
          e.level  = {1'b0, (rb[j] & m) != 8'h00};
          ev.push_back(e);
        end
      end
    end
    for (int j = 0; j < NUM_PANEL_KEYS; j++) begin
      panel_key(j, slot, m, sh);
      if ((rb[slot] & m) != (held[slot] & m)) begin
        held[slot] = (held[slot] & ~m) | (rb[slot] & m);
        e          = '0;
        e.kind     = kpce_pkg::KIND_KEY;
        e.code     = 6'(FIRST_PANEL_CODE + j);
        e.level    = 2'((rb[slot] & m) >> sh);
        ev.push_back(e);
      end
    end
    if ((sx != 8'h00 || sy != 8'h00) && stick_en && (sx != stored_x || sy != stored_y)) begin
      stored_x = sx;
      stored_y = sy;
      e        = '0;
      e.kind   = kpce_pkg::KIND_STICK;
      e.sx     = sx;
      e.sy     = sy;
      ev.push_back(e);
    end
    foreach (ev[k]) begin
      e      = ev[k];
      e.last = (k == ev.size() - 1);
      events_due.push_back(e);
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_event();
    kp_event_t e;
    events_seen++;
    if (events_due.size() == 0) begin
      $error("event word with none due: tdata %h tuser %b tlast %b",
             out_tdata, out_tuser, out_tlast);
      errors++;
    end else begin
      e = events_due.pop_front();
      check_field("event_kind", e.kind, out_tuser);
      check_field("key_code", e.code, out_tdata[5:0]);
      check_field("key_level", e.level, out_tdata[7:6]);
      check_field("stick_x", e.sx, out_tdata[15:8]);
      check_field("stick_y", e.sy, out_tdata[23:16]);
      check_field("last", e.last, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) begin
        held[k] = 8'h00;
      end
      stored_x     = 8'h00;
      stored_y     = 8'h00;
      stick_en     = 1'b0;
      errors       = 0;
      reports_seen = 0;
      events_seen  = 0;
      events_due.delete();
    end else begin
      if (cfg_we) begin
        stick_en = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        check_event();
      end
      if (in_tvalid && in_tready) begin
        reports_seen++;
        predict_report(in_tdata);
      end
    end
    waiting <= events_due.size();
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the keypad change event unit. A directed run covers full
// press and release of every key, ignored bits, brightness steps and the
// stick cases; then random report sequences run under sender gaps and
// receiver stalls, with one long receiver hold that backs up the input.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_LEN      = 300;
  localparam int PHASE_ITEMS   = 22;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int   errors;
  int   waiting;
  int   reports_seen;
  int   events_seen;
  int   idle_in     = 0;
  int   stall_out   = 0;
  int   cfg_writes  = 0;
  logic hold_token  = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;
  logic [55:0] prev_report = '0;

  always #5 clk = ~clk;

  keypad_report_change_events_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  kpce_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .errors       (errors),
    .waiting      (waiting),
    .reports_seen (reports_seen),
    .events_seen  (events_seen)
  );

  // receiver: random stalls, plus a long hold each time the token flips
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_out);
    end
  end

  function automatic logic [55:0] report(input logic [7:0] sx, input logic [7:0] sy,
                                         input logic [7:0] g_lo, input logic [7:0] g_mid,
                                         input logic [7:0] g_hi, input logic [7:0] panel,
                                         input logic [7:0] extra);
    return {extra, panel, g_hi, g_mid, g_lo, sy, sx};
  endfunction

  // mostly a few keys toggled against the last report, sometimes a repeat
  // or a fully random report; stick often parked at the origin
  function automatic logic [55:0] next_report(input logic [55:0] prev);
    logic [55:0] w;
    int          pick;
    int          stick;
    int          pos;
    pick  = $urandom_range(99);
    stick = $urandom_range(99);
    w     = prev;
    if (pick < 10) begin
      w = 56'({$urandom, $urandom});
    end else if (pick >= 20) begin
      repeat ($urandom_range(4, 1)) begin
        pos    = $urandom_range(55, 16);
        w[pos] = ~w[pos];
      end
    end
    if (stick < 25) begin
      w[15:0] = '0;
    end else if (stick >= 55) begin
      w[15:0] = 16'($urandom);
    end
    return w;
  endfunction

  task automatic send_report(input logic [55:0] w);
    if ($urandom_range(99) < idle_in) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_in);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stick_enable(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input logic en);
    settle();
    write_stick_enable(en);
    idle_in   = idle_pct;
    stall_out <= stall_pct;
    repeat (PHASE_ITEMS) begin
      prev_report = next_report(prev_report);
      send_report(prev_report);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_stick_enable(1'b0);
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h98));
    settle();

    write_stick_enable(1'b1);
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h60));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00));
    send_report(report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h00));
    send_report(report(8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(report(8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();

    write_stick_enable(1'b0);
    send_report(report(8'h7F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();

    write_stick_enable(1'b1);
    send_report(report(8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8'h7F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    prev_report = report(8'h7F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    random_phase(0, 0, 1'b1);
    random_phase(63, 0, 1'b0);
    random_phase(0, 63, 1'b1);
    random_phase(9, 9, 1'b1);

    // long receiver hold while heavy reports keep coming
    settle();
    idle_in    = 0;
    stall_out  <= 0;
    hold_token <= ~hold_token;
    for (int k = 0; k < 12; k++) begin
      prev_report = (k % 2 == 0) ? {40'hFF_FFFF_FFFF, 8'(k + 1), 8'(k + 2)}
                                 : {40'h00_0000_0000, 8'(k + 1), 8'(k + 2)};
      send_report(prev_report);
    end
    settle();

    $display("ran %0d reports, checked %0d events, %0d stick enable writes",
             reports_seen, events_seen, cfg_writes);
    $display("phases: directed, free flow, sender gaps, receiver stalls, both, long hold");
    if (errors == 0 && waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d events still due", waiting);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
src/kpce_pkg.sv
src/kpce_detect.sv
src/keypad_report_change_events_unit.sv
sim/kpce_checker.sv
sim/tb.sv
